>>> rtl/core/assert_macros.svh
// Assertion helpers; bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> rtl/core/dsdq_pkg.sv
`timescale 1ns / 1ps

package dsdq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;
  localparam int DEFAULT_COORD_BITS  = 16;
  localparam int KIND_BITS           = 8;
  localparam int VARIANT_BITS        = 8;

  // action codes carried on s_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // command broadcast to every cell in the chain
  typedef struct packed {
    logic load_new;   // insert the incoming entry
    logic shift_out;  // move every entry one cell toward the head
  } dsdq_cmd_t;

endpackage

>>> rtl/core/depth_sorted_draw_queue.sv
`timescale 1ns / 1ps

// Painter's-order draw queue.
// Slave channel (s_*): one word per command. s_tuser selects the action:
// insert places the tile entry in ascending x+y order (newest first among
// equal keys); flush emits all stored entries in order and empties the queue.
// Master channel (m_*): one word per emitted entry, m_tlast on the final one,
// m_tuser = overflow flag (some insert was dropped since the previous flush).
// The store is a chain of cells; every cell compares its own key with the
// incoming one and shifts to its right neighbor in the same cycle, so an
// insert leaves s_tready high and the next command is accepted right after.
// A flush drains the chain toward the head, one entry per cycle unless the
// receiver stalls, and holds s_tready low until every stored entry has left
// the chain; the state switches to draining before the first word is loaded.
// A flush of an empty queue emits nothing and only clears the overflow flag.
// Inserts into a full queue are dropped and set the overflow flag.
// Reset empties the queue and clears the flag; the output register holds its
// word while m_tready is low and the chain waits with it.

`include "assert_macros.svh"

module depth_sorted_draw_queue #(
  parameter int QUEUE_DEPTH = dsdq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int COORD_BITS  = dsdq_pkg::DEFAULT_COORD_BITS,
  parameter int ENT_W       = 2 * COORD_BITS + dsdq_pkg::KIND_BITS + dsdq_pkg::VARIANT_BITS,
  parameter int TDATA_W     = ((ENT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // tile_x, tile_y, structure_kind, structure_variant
  input  logic               s_tuser,   // action (0 insert, 1 flush)
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // out_x, out_y, out_kind, out_variant
  output logic               m_tlast,   // is_last
  output logic               m_tuser    // overflowed
);
  import dsdq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic             drop;
  logic             flush_ovf;

  logic             in_acc;
  logic             out_free;
  dsdq_cmd_t        cmd;

  logic [ENT_W-1:0]       new_ent;
  logic [COORD_BITS-1:0]  new_x;
  logic [COORD_BITS-1:0]  new_y;
  logic [COORD_BITS:0]    new_key;

  // chain taps: cell i drives index i+1; ends are tied off
  logic [ENT_W-1:0] ent_c [QUEUE_DEPTH+2];
  logic             ge_c  [QUEUE_DEPTH+1];
  logic             occ_c [QUEUE_DEPTH+1];

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign new_ent = s_tdata[ENT_W-1:0];
  assign new_x   = new_ent[COORD_BITS-1:0];
  assign new_y   = new_ent[2*COORD_BITS-1:COORD_BITS];
  assign new_key = {new_x[COORD_BITS-1], new_x} + {new_y[COORD_BITS-1], new_y};

  // drop inserts into a full queue
  assign cmd.load_new  = in_acc && (s_tuser == ACT_INSERT) && (count != CNT_W'(QUEUE_DEPTH));
  assign cmd.shift_out = (state == ST_DRAIN) && out_free;

  assign ent_c[0]             = '0;
  assign ent_c[QUEUE_DEPTH+1] = '0;
  assign ge_c[0]              = 1'b0;
  assign occ_c[0]             = 1'b1;  // head cell always sees an occupied left side

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_chain
    dsdq_cell #(
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i),
      .ENT_W      (ENT_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .new_ent  (new_ent),
      .new_key  (new_key),
      .prev_ge  (ge_c[i]),
      .prev_occ (occ_c[i]),
      .prev_ent (ent_c[i]),
      .next_ent (ent_c[i+2]),
      .ent      (ent_c[i+1]),
      .ge       (ge_c[i+1]),
      .occ      (occ_c[i+1])
    );
  end

  // control: fill count, overflow flag, drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      drop      <= 1'b0;
      flush_ovf <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser == ACT_FLUSH) begin
              flush_ovf <= drop;
              drop      <= 1'b0;
              if (count != '0) begin
                state <= ST_DRAIN;
              end
            end else if (cmd.load_new) begin
              count <= count + CNT_W'(1);
            end else begin
              drop <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (cmd.shift_out) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: load the head word, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.shift_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_out) begin
      m_tdata <= TDATA_W'(ent_c[1]);
      m_tlast <= (count == CNT_W'(1));
      m_tuser <= flush_ovf;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(QUEUE_DEPTH))
  `ASSERT_PROP(a_drain_nonempty, clk, rst, (state == ST_DRAIN) |-> (count != '0))
  `ASSERT_PROP(a_last_ends_drain, clk, rst, (cmd.shift_out && count == CNT_W'(1)) |=> (state == ST_IDLE && count == '0 && m_tlast))
  `ASSERT_PROP(a_full_sets_drop, clk, rst, (in_acc && s_tuser == ACT_INSERT && count == CNT_W'(QUEUE_DEPTH)) |=> drop)
  `ASSERT_NEVER(a_load_only_idle, clk, rst, cmd.load_new && cmd.shift_out)

endmodule

>>> rtl/core/dsdq_cell.sv
`timescale 1ns / 1ps

module dsdq_cell #(
  parameter int COORD_BITS = dsdq_pkg::DEFAULT_COORD_BITS,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0,
  parameter int ENT_W      = 2 * COORD_BITS + dsdq_pkg::KIND_BITS + dsdq_pkg::VARIANT_BITS
) (
  input  logic                  clk,
  input  dsdq_pkg::dsdq_cmd_t   cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [ENT_W-1:0]      new_ent,
  input  logic [COORD_BITS:0]   new_key,
  input  logic                  prev_ge,
  input  logic                  prev_occ,
  input  logic [ENT_W-1:0]      prev_ent,
  input  logic [ENT_W-1:0]      next_ent,
  output logic [ENT_W-1:0]      ent,
  output logic                  ge,
  output logic                  occ
);
  import dsdq_pkg::*;

  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic [COORD_BITS:0]   key;
  logic [ENT_W-1:0]      ent_next;

  assign x   = ent[COORD_BITS-1:0];
  assign y   = ent[2*COORD_BITS-1:COORD_BITS];
  assign key = {x[COORD_BITS-1], x} + {y[COORD_BITS-1], y};
  assign occ = (count > CNT_W'(IDX));
  assign ge  = occ && ($signed(key) >= $signed(new_key));

  always_comb begin
    ent_next = ent;
    if (cmd.shift_out) begin
      ent_next = next_ent;
    end else if (cmd.load_new) begin
      // shift right behind the insertion point, take the new word at it
      if (prev_ge) begin
        ent_next = prev_ent;
      end else if (ge || (!occ && prev_occ)) begin
        ent_next = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
